FILE: sv/smvlq_pkg.sv
// ----------------------------------------------------------------------------
// smvlq_pkg
// shared types, character codes and base64 digit mapping for the segment
// vlq encoder
// ----------------------------------------------------------------------------
package smvlq_pkg;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        REQ_LOCATION = 2'd0,
        REQ_FUNCTION = 2'd1,
        REQ_EOL      = 2'd2,
        REQ_CLEAR    = 2'd3
    } t_req;

    // segment field order
    typedef enum logic [2:0] {
        FLD_GCOL = 3'd0,
        FLD_FILE = 3'd1,
        FLD_LINE = 3'd2,
        FLD_COL  = 3'd3,
        FLD_NAME = 3'd4
    } t_fld;

    localparam int VAL_W  = 20;          // widest delta operand (zero-based line)
    localparam int CODE_W = VAL_W + 1;   // magnitude with sign in bit 0
    localparam int DIG_W  = 5;

    localparam logic [6:0] CHAR_COMMA = 7'h2C;
    localparam logic [6:0] CHAR_SEMI  = 7'h3B;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] CHAR_LOWER = 7'h61;
    localparam logic [6:0] CHAR_DIGIT = 7'h30;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;

    // base64 alphabet A-Z a-z 0-9 + /
    function automatic logic [6:0] b64_char(input logic [5:0] d);
        logic [6:0] dd;
        dd = {1'b0, d};
        if (d < 6'd26) begin
            b64_char = CHAR_UPPER + dd;
        end else if (d < 6'd52) begin
            b64_char = CHAR_LOWER + dd - 7'd26;
        end else if (d < 6'd62) begin
            b64_char = CHAR_DIGIT + dd - 7'd52;
        end else if (d == 6'd62) begin
            b64_char = CHAR_PLUS;
        end else begin
            b64_char = CHAR_SLASH;
        end
    endfunction

endpackage

FILE: sv/smvlq_vlq_unit.sv
// ----------------------------------------------------------------------------
// smvlq_vlq_unit
// shared delta coder and digit slicer: turns a pair of values into a
// sign-folded vlq code, and peels one base64 digit off a code
// ----------------------------------------------------------------------------
module smvlq_vlq_unit
    import smvlq_pkg::*;
(
    input  logic [VAL_W-1:0]  i_now,
    input  logic [VAL_W-1:0]  i_before,
    input  logic [CODE_W-1:0] i_code,
    output logic [CODE_W-1:0] o_code,
    output logic [CODE_W-1:0] o_rest,
    output logic [6:0]        o_char,
    output logic              o_more
);

    logic [VAL_W:0]   diff;
    logic             neg;
    logic [VAL_W-1:0] mag;

    // signed difference folded to magnitude with sign in bit 0
    always_comb begin
        diff = {1'b0, i_now} - {1'b0, i_before};
        neg  = diff[VAL_W];
        mag  = neg ? (~diff[VAL_W-1:0] + 1'b1) : diff[VAL_W-1:0];
    end
    assign o_code = {mag, neg};

    // low five bits out, continuation flag when anything remains
    assign o_rest = i_code >> DIG_W;
    assign o_more = (o_rest != '0);
    assign o_char = b64_char({o_more, i_code[DIG_W-1:0]});

endmodule

FILE: sv/source_map_segment_vlq_encoder.sv
// ----------------------------------------------------------------------------
// source_map_segment_vlq_encoder
// source-map v3 mapping segment encoder producing base64 vlq characters
// ----------------------------------------------------------------------------
// One input word is taken when the encoder is idle, and it then streams the
// characters of that word out through a single output register. Each delta
// value is first loaded through the shared delta coder and then goes out one
// character per digit, so a location word gives an optional comma separator
// and four deltas, a function word adds a name delta, an end of line gives a
// semicolon and then any held segment, and a clear gives no characters.
// Backpressure on the output holds the stream. The last character of each
// word that gives characters carries tlast.
module source_map_segment_vlq_encoder
    import smvlq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] gen_column, [23:16] file_index, [44:24] src_line,
    // [61:45] src_column, [73:62] name_index, [79:74] zero
    input  logic [79:0] i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [6:0] char_code, [7] zero
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEMI = 5'b00010,
        ST_SEP  = 5'b00100,
        ST_LOAD = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // input fields
    logic [15:0] s_gcol;
    logic [7:0]  s_file;
    logic [20:0] s_line;
    logic [16:0] s_col;
    logic [11:0] s_name;
    t_req        s_req;
    logic        s_acc;

    assign s_gcol = i_s_tdata[15:0];
    assign s_file = i_s_tdata[23:16];
    assign s_line = i_s_tdata[44:24];
    assign s_col  = i_s_tdata[61:45];
    assign s_name = i_s_tdata[73:62];
    assign s_req  = t_req'(i_s_tuser);
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc  = i_s_tvalid && o_s_tready;

    // previous segment and held location
    logic [15:0] r_prev_gcol;
    logic [7:0]  r_prev_file;
    logic [19:0] r_prev_line;
    logic [15:0] r_prev_col;
    logic [11:0] r_prev_name;
    logic        r_at_start;
    logic        r_held_valid;
    logic [7:0]  r_held_file;
    logic [20:0] r_held_line;
    logic [16:0] r_held_col;

    // operands of the segment in progress
    logic [15:0] r_gcol;
    logic [7:0]  r_file;
    logic [19:0] r_line0;
    logic [15:0] r_col0;
    logic [11:0] r_name;
    logic        r_with_name;
    t_fld        r_fld;
    logic [CODE_W-1:0] r_code;

    // output register
    logic        r_m_valid;
    logic [6:0]  r_m_char;
    logic        r_m_last;

    logic [19:0] held_line0;
    logic [15:0] held_col0;
    assign held_line0 = 20'(r_held_line - 21'd1);
    assign held_col0  = 16'(r_held_col - 17'd1);

    // operand selection for the shared unit
    logic [VAL_W-1:0] u_now, u_before;
    always_comb begin
        case (r_fld)
            FLD_GCOL: begin
                u_now    = VAL_W'(r_gcol);
                u_before = VAL_W'(r_prev_gcol);
            end
            FLD_FILE: begin
                u_now    = VAL_W'(r_file);
                u_before = VAL_W'(r_prev_file);
            end
            FLD_LINE: begin
                u_now    = r_line0;
                u_before = r_prev_line;
            end
            FLD_COL: begin
                u_now    = VAL_W'(r_col0);
                u_before = VAL_W'(r_prev_col);
            end
            FLD_NAME: begin
                u_now    = VAL_W'(r_name);
                u_before = VAL_W'(r_prev_name);
            end
            default: begin
                u_now    = '0;
                u_before = '0;
            end
        endcase
    end

    logic [CODE_W-1:0] u_code, u_rest;
    logic [6:0]        u_char;
    logic              u_more;

    smvlq_vlq_unit u_vlq (
        .i_now    (u_now),
        .i_before (u_before),
        .i_code   (r_code),
        .o_code   (u_code),
        .o_rest   (u_rest),
        .o_char   (u_char),
        .o_more   (u_more)
    );

    logic out_free;
    logic last_fld;
    assign out_free = !r_m_valid || i_m_tready;
    assign last_fld = r_with_name ? (r_fld == FLD_NAME) : (r_fld == FLD_COL);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_req)
                        REQ_LOCATION, REQ_FUNCTION: n_state = r_at_start ? ST_LOAD : ST_SEP;
                        REQ_EOL:                    n_state = ST_SEMI;
                        default:                    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEMI: begin
                if (out_free) n_state = r_held_valid ? ST_LOAD : ST_IDLE;
            end
            ST_SEP: begin
                if (out_free) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free && !u_more) n_state = last_fld ? ST_IDLE : ST_LOAD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_at_start   <= 1'b1;
            r_held_valid <= 1'b0;
            r_prev_gcol  <= '0;
            r_prev_file  <= '0;
            r_prev_line  <= '0;
            r_prev_col   <= '0;
            r_prev_name  <= '0;
            r_held_file  <= '0;
            r_held_line  <= '0;
            r_held_col   <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // accept a word
            if (s_acc) begin
                case (s_req)
                    REQ_LOCATION: begin
                        r_held_valid <= 1'b1;
                        r_held_file  <= s_file;
                        r_held_line  <= s_line;
                        r_held_col   <= s_col;
                        r_at_start   <= 1'b0;
                    end
                    REQ_FUNCTION: r_at_start <= 1'b0;
                    REQ_EOL: begin
                        r_at_start  <= 1'b1;
                        r_prev_gcol <= '0;
                    end
                    default: r_held_valid <= 1'b0;
                endcase
            end
            // held segment after the semicolon starts a fresh line
            if (r_state == ST_SEMI && out_free && r_held_valid) begin
                r_at_start <= 1'b0;
            end
            // previous values move up as each field is coded
            if (r_state == ST_LOAD) begin
                case (r_fld)
                    FLD_GCOL: r_prev_gcol <= r_gcol;
                    FLD_FILE: r_prev_file <= r_file;
                    FLD_LINE: r_prev_line <= r_line0;
                    FLD_COL:  r_prev_col  <= r_col0;
                    FLD_NAME: r_prev_name <= r_name;
                    default:  r_prev_name <= r_prev_name;
                endcase
            end
            // output valid
            if (out_free && (r_state == ST_SEMI || r_state == ST_SEP
                             || r_state == ST_EMIT)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_gcol      <= s_gcol;
            r_file      <= s_file;
            r_line0     <= 20'(s_line - 21'd1);
            r_col0      <= (s_req == REQ_LOCATION) ? 16'(s_col - 17'd1) : 16'd0;
            r_name      <= s_name;
            r_with_name <= (s_req == REQ_FUNCTION);
            r_fld       <= FLD_GCOL;
        end
        if (r_state == ST_SEMI && out_free) begin
            r_gcol      <= '0;
            r_file      <= r_held_file;
            r_line0     <= held_line0;
            r_col0      <= held_col0;
            r_with_name <= 1'b0;
            r_fld       <= FLD_GCOL;
        end
        if (r_state == ST_LOAD) begin
            r_code <= u_code;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_code <= u_rest;
            if (!u_more && !last_fld) r_fld <= t_fld'(r_fld + 3'd1);
        end
        // output character
        if (out_free) begin
            case (r_state)
                ST_SEMI: begin
                    r_m_char <= CHAR_SEMI;
                    r_m_last <= !r_held_valid;
                end
                ST_SEP: begin
                    r_m_char <= CHAR_COMMA;
                    r_m_last <= 1'b0;
                end
                ST_EMIT: begin
                    r_m_char <= u_char;
                    r_m_last <= !u_more && last_fld;
                end
                default: begin
                    r_m_char <= r_m_char;
                    r_m_last <= r_m_last;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_char};
    assign o_m_tlast  = r_m_last;

endmodule

FILE: sv/smvlq_checker.sv
// ----------------------------------------------------------------------------
// smvlq_checker
// port-level checks of the segment vlq encoder, bound to the top level
// ----------------------------------------------------------------------------
module smvlq_checker
    import smvlq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [79:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // a clear word leaves the encoder ready at once
    a_clear_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == REQ_CLEAR) |=> o_s_tready)
        else $error("not ready after clear word");

    // any other word keeps the input closed while its characters go out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != REQ_CLEAR) |=> !o_s_tready)
        else $error("ready during a run of characters");

    // a run that has not ended keeps the input closed
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("ready before the last character of a run");

endmodule

bind source_map_segment_vlq_encoder smvlq_checker u_smvlq_checker (.*);
